>>> design/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// shared constants and types
// ----------------------------------------------------------------------------
package bec_pkg;

  localparam int unsigned MaxLengthDef    = 65536;
  localparam int unsigned FractionBitsDef = 12;
  localparam int unsigned Bins            = 256;
  localparam int unsigned BinW            = 8;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [CfgIdxW-1:0] CfgPlain  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSingle = 1'b1;

  localparam logic [1:0] ClsPlain  = 2'd0;
  localparam logic [1:0] ClsSingle = 2'd1;
  localparam logic [1:0] ClsBlock  = 2'd2;

  localparam logic [15:0] PlainRst  = 16'd18432;
  localparam logic [15:0] SingleRst = 16'd24576;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOGN,
    ST_LOGN_WAIT,
    ST_READ,
    ST_READ_WAIT,
    ST_LOGC,
    ST_LOGC_WAIT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> design/byte_entropy_classifier_top.sv
// ----------------------------------------------------------------------------
// byte_entropy_classifier_top
// byte histogram, shannon entropy and three-way buffer class
// ----------------------------------------------------------------------------
// Bytes are counted one at a time: after each counted byte busy is high for
// one cycle while the bin increment is written back to the ram. A byte with
// in_last_byte or a transfer with in_empty_buffer launches the entropy walk,
// and busy is high through the result strobe. The walk takes one log2 of the
// total count and then, for each of the 256 bins, a ram read plus, for
// nonzero bins, a log2 and a multiply-accumulate step, all on one shared log2
// unit; a bin scan also writes zero back so the histogram is clear for the
// next buffer. A final restoring divide shifts in one quotient bit for each
// sum bit. After reset a clearing pass, with busy high, writes zero to every
// bin. out_valid is high for exactly one cycle with the result; the receiver
// cannot stall it.
module byte_entropy_classifier_top import bec_pkg::*; #(
  parameter int unsigned MAX_LENGTH    = MaxLengthDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic                in_empty_buffer,
  output logic                out_valid,
  output logic [1:0]          out_buffer_class,
  output logic [15:0]         out_entropy_bits,
  output logic                out_length_overflow,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // count width holds MAX_LENGTH itself
  localparam int unsigned CntW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned KW   = $clog2(CntW);
  localparam int unsigned LW   = KW + FRACTION_BITS;
  localparam int unsigned SumW = CntW + LW + 1;
  localparam int unsigned DW   = $clog2(SumW + 1);

  state_t state_r, state_nxt;

  logic [15:0]       plain_thr_r, single_thr_r;
  logic [CntW-1:0]   total_r, total_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BinW-1:0]   bin_r, bin_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]     logn_r, logn_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic [SumW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]     dcnt_r, dcnt_nxt;
  logic              pend_r, pend_nxt; // a counted byte still in the ram write
  logic [BinW-1:0]   pbin_r, pbin_nxt;

  logic              ram_we;
  logic [BinW-1:0]   ram_waddr, ram_raddr;
  logic [CntW-1:0]   ram_wdata, ram_rdata;

  logic              lg_start;
  logic              lg_done;
  logic [CntW-1:0]   lg_x;
  logic [LW-1:0]     lg_res;

  logic              take;
  logic              cnt_ok;
  logic [SumW:0]     rem_sh;
  logic [15:0]       ent;

  bec_ram #(.WIDTH(CntW), .DEPTH(Bins)) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bec_log2 #(.XW(CntW), .FRACW(FRACTION_BITS)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .x     (lg_x),
    .done  (lg_done),
    .result(lg_res)
  );

  assign take    = start && !busy;
  assign cnt_ok  = total_r < CntW'(MAX_LENGTH);
  assign rem_sh  = {rem_r, sum_r[SumW-1]};

  // saturate the quotient into 16 bits
  assign ent = (sum_r[SumW-1:16] != '0) ? 16'hFFFF : sum_r[15:0];

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_thr_r  <= PlainRst;
      single_thr_r <= SingleRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgPlain:  plain_thr_r  <= cfg_data;
        CfgSingle: single_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    logn_nxt  = logn_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    pend_nxt  = 1'b0;
    pbin_nxt  = pbin_r;
    ram_we    = 1'b0;
    ram_waddr = bin_r;
    ram_wdata = '0;
    ram_raddr = in_data_byte;
    lg_start  = 1'b0;
    lg_x      = total_r;
    busy      = 1'b1;
    out_valid = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        bin_nxt = bin_r + 1'b1;
        if (bin_r == BinW'(Bins - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = pend_r;
        // read for this byte was issued last cycle; commit increment
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pbin_r;
          ram_wdata = ram_rdata + 1'b1;
        end
        if (take) begin
          if (in_empty_buffer) begin
            state_nxt = ST_LOGN;
          end else begin
            if (cnt_ok) begin
              total_nxt = total_r + 1'b1;
              pend_nxt  = 1'b1;
              pbin_nxt  = in_data_byte;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_last_byte) state_nxt = ST_LOGN;
          end
        end
      end
      ST_LOGN: begin
        // finish a pending increment before the walk
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pbin_r;
          ram_wdata = ram_rdata + 1'b1;
        end
        sum_nxt = '0;
        bin_nxt = '0;
        if (total_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          lg_start  = 1'b1;
          state_nxt = ST_LOGN_WAIT;
        end
      end
      ST_LOGN_WAIT: begin
        if (lg_done) begin
          logn_nxt  = lg_res;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_raddr = bin_r;
        state_nxt = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cnt_nxt = ram_rdata;
        ram_we  = 1'b1; // clear bin behind the scan
        if (ram_rdata == '0) begin
          bin_nxt = bin_r + 1'b1;
          if (bin_r == BinW'(Bins - 1)) state_nxt = ST_DIV;
          else state_nxt = ST_READ;
        end else begin
          state_nxt = ST_LOGC;
        end
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      ST_LOGC: begin
        lg_x      = cnt_r;
        lg_start  = 1'b1;
        state_nxt = ST_LOGC_WAIT;
      end
      ST_LOGC_WAIT: begin
        if (lg_done) begin
          logn_nxt  = logn_r;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        sum_nxt = sum_r + SumW'(cnt_r) * SumW'(logn_r - lg_res);
        bin_nxt = bin_r + 1'b1;
        rem_nxt  = '0;
        dcnt_nxt = '0;
        if (bin_r == BinW'(Bins - 1)) state_nxt = ST_DIV;
        else state_nxt = ST_READ;
      end
      ST_DIV: begin
        // restoring divide, quotient shifts into sum_r
        if (rem_sh >= {1'b0, SumW'(total_r)}) begin
          rem_nxt = SumW'(rem_sh - {1'b0, SumW'(total_r)});
          sum_nxt = {sum_r[SumW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[SumW-1:0];
          sum_nxt = {sum_r[SumW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DW'(SumW - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        total_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      total_r <= '0;
      ovf_r   <= 1'b0;
      bin_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      bin_r   <= bin_nxt;
      pend_r  <= pend_nxt;
    end
    pbin_r <= pbin_nxt;
    cnt_r  <= cnt_nxt;
    logn_r <= logn_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
  end

  // class compare on the finished entropy
  always_comb begin
    if (total_r == '0 || ent <= plain_thr_r) out_buffer_class = ClsPlain;
    else if (ent < single_thr_r)             out_buffer_class = ClsSingle;
    else                                     out_buffer_class = ClsBlock;
  end

  assign out_entropy_bits    = (total_r == '0) ? 16'd0 : ent;
  assign out_length_overflow = ovf_r;

endmodule

>>> design/bec_ram.sv
// ----------------------------------------------------------------------------
// bec_ram
// generic simple dual-port ram (one write port, one read port), registered read
// ----------------------------------------------------------------------------
module bec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bec_log2.sv
// ----------------------------------------------------------------------------
// bec_log2
// iterative fixed-point log2: priority encode, then one squaring per cycle
// ----------------------------------------------------------------------------
module bec_log2 import bec_pkg::*; #(
  parameter int unsigned XW    = 17,
  parameter int unsigned FRACW = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [XW-1:0]                   x,
  output logic                            done,
  output logic [$clog2(XW)+FRACW-1:0]     result
);

  localparam int unsigned KW = $clog2(XW);
  localparam int unsigned CW = $clog2(FRACW + 1);

  logic [31:0]    m_r, m_nxt;
  logic [FRACW-1:0] frac_r, frac_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [63:0]    sq;
  logic [32:0]    sqs;
  logic [KW-1:0]  kf;

  always_comb begin
    kf = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) kf = KW'(i);
    end
  end

  assign sq  = 64'(m_r) * 64'(m_r);
  assign sqs = sq[62:30];

  always_comb begin
    m_nxt    = m_r;
    frac_nxt = frac_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      k_nxt    = kf;
      m_nxt    = 32'(({15'd0, x} << (5'd30 - 5'(kf))));
      frac_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (sqs[32:31] != 2'b00) begin
        frac_nxt = {frac_r[FRACW-2:0], 1'b1};
        m_nxt    = sqs[32:1];
      end else begin
        frac_nxt = {frac_r[FRACW-2:0], 1'b0};
        m_nxt    = sqs[31:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(FRACW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
  end

  assign done   = done_r;
  assign result = {k_r, frac_r};

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// byte entropy classifier testbench
// streams byte buffers into the classifier, predicts the entropy and the
// class of each buffer from its own histogram model and checks every result
// ----------------------------------------------------------------------------
module testbench import bec_pkg::*; ();

  localparam int unsigned MaxLen   = MaxLengthDef;
  localparam int unsigned FracBits = FractionBitsDef;
  // worst entropy walk plus the clearing pass, with margin
  localparam int unsigned WalkCycles = 256 * (FracBits + 5) + 600;

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] entropy;
    logic        overflow;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [7:0] in_data_byte;
  logic in_last_byte;
  logic in_empty_buffer;
  logic out_valid;
  logic [1:0] out_buffer_class;
  logic [15:0] out_entropy_bits;
  logic out_length_overflow;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // predictor state
  int unsigned bin_count [Bins];
  int unsigned byte_total;
  bit          dropped;
  logic [15:0] plain_limit;
  logic [15:0] single_limit;

  verdict_t pending_verdicts[$];
  int unsigned errors;
  int unsigned buffers_done;
  int unsigned bytes_sent;

  byte_entropy_classifier_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .in_empty_buffer(in_empty_buffer), .out_valid(out_valid),
    .out_buffer_class(out_buffer_class), .out_entropy_bits(out_entropy_bits),
    .out_length_overflow(out_length_overflow), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // truncated log2 with FracBits fraction bits, by repeated squaring
  function automatic longint unsigned log2_fixed(int unsigned x);
    int unsigned k;
    longint unsigned m;
    longint unsigned frac;
    k = 0;
    frac = 0;
    if (x == 0) return 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = longint'(x) << (30 - k);
    for (int b = 0; b < FracBits; b++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(k) << FracBits) | frac;
  endfunction

  function automatic logic [15:0] histogram_entropy();
    longint unsigned ln;
    longint unsigned acc;
    longint unsigned h;
    acc = 0;
    if (byte_total == 0) return 16'd0;
    ln = log2_fixed(byte_total);
    for (int i = 0; i < Bins; i++)
      if (bin_count[i] != 0)
        acc += longint'(bin_count[i]) * (ln - log2_fixed(bin_count[i]));
    h = acc / byte_total;
    if (h > 64'hFFFF) h = 64'hFFFF;
    return h[15:0];
  endfunction

  function automatic void clear_histogram();
    foreach (bin_count[i]) bin_count[i] = 0;
    byte_total = 0;
    dropped = 0;
  endfunction

  // update the histogram model for one transfer, queue a verdict on buffer end
  function automatic void predict_transfer(logic [7:0] b, logic last, logic empty);
    verdict_t v;
    if (!empty) begin
      if (byte_total >= MaxLen) begin
        dropped = 1;
      end else begin
        bin_count[b]++;
        byte_total++;
      end
      if (!last) return;
    end
    v.entropy = histogram_entropy();
    if (v.entropy <= plain_limit) v.cls = ClsPlain;
    else if (v.entropy < single_limit) v.cls = ClsSingle;
    else v.cls = ClsBlock;
    v.overflow = dropped;
    pending_verdicts.push_back(v);
    clear_histogram();
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d (buffer %0d)", what, got, want, buffers_done);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        v = pending_verdicts.pop_front();
        if (out_buffer_class !== v.cls)
          report_mismatch("class", 32'(out_buffer_class), 32'(v.cls));
        if (out_entropy_bits !== v.entropy)
          report_mismatch("entropy", 32'(out_entropy_bits), 32'(v.entropy));
        if (out_length_overflow !== v.overflow)
          report_mismatch("overflow", 32'(out_length_overflow), 32'(v.overflow));
      end
      buffers_done++;
    end
  end

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // no gap most often, else mostly short gaps and a few long ones
  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    if (r < 95) idle_cycles($urandom_range(1, 3));
    else idle_cycles($urandom_range(10, 40));
  endtask

  // one transfer: present the item, hold start until busy is low at an edge
  task automatic send_byte(logic [7:0] b, logic last, logic empty);
    start <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    in_empty_buffer <= empty;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_transfer(b, last, empty);
    bytes_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgPlain) plain_limit = val;
    else single_limit = val;
  endtask

  // a buffer of n bytes drawn from an alphabet of the given size
  task automatic send_buffer(int unsigned n, int unsigned alphabet, bit gaps);
    logic [7:0] base;
    base = 8'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(base + 8'($urandom_range(0, alphabet - 1)), i == n - 1, 1'b0);
      if (gaps) random_gap();
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0, 1'b1);          // empty buffer
    send_byte(8'hFF, 1'b1, 1'b1);          // both flags, empty wins
    send_byte(8'hFF, 1'b1, 1'b0);          // single byte
    for (int i = 0; i < 8; i++) send_byte(8'(1 << i), i == 7, 1'b0); // bit walk
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);          // empty flag after bytes
    for (int i = 0; i < 10; i++) send_byte(8'h41, i == 9, 1'b0); // one repeated value
  endtask

  task automatic test_full_alphabet();
    // all 256 values once: entropy of exactly 8 bits
    for (int i = 0; i < 256; i++) send_byte(8'(i), i == 255, 1'b0);
  endtask

  task automatic test_thresholds();
    write_threshold(CfgPlain, 16'd0);
    write_threshold(CfgSingle, 16'hFFFF);
    send_buffer(20, 16, 1);
    send_buffer(1, 1, 0);
    write_threshold(CfgPlain, 16'hFFFF);
    send_buffer(30, 256, 1);
    write_threshold(CfgPlain, 16'd8192);
    write_threshold(CfgSingle, 16'd12288);
    for (int i = 0; i < 12; i++) send_buffer($urandom_range(1, 24), 1 << (i % 9), 1);
    write_threshold(CfgPlain, 16'd32768);
    write_threshold(CfgSingle, 16'd0);
    send_buffer(16, 64, 0);
    write_threshold(CfgPlain, PlainRst);
    write_threshold(CfgSingle, SingleRst);
  endtask

  task automatic test_random();
    int unsigned r;
    while (bytes_sent < 700) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_buffer($urandom_range(1, 20), 1 << $urandom_range(0, 8), 1);
      else if (r < 90) send_byte(8'($urandom), 1'($urandom), 1'b1);
      else send_byte(8'($urandom), 1'($urandom), 1'b0);
      if ($urandom_range(0, 19) == 0) drain();     // hold off until all results are in
    end
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    in_empty_buffer = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    buffers_done = 0;
    bytes_sent = 0;
    clear_histogram();
    plain_limit = PlainRst;
    single_limit = SingleRst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_alphabet();
    test_thresholds();
    test_random();

    drain();
    idle_cycles(WalkCycles);
    $display("sent %0d transfers, checked %0d buffer results", bytes_sent, buffers_done);
    $display("covered empty and full-alphabet buffers and extreme thresholds");
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: every transfer may launch a full walk
  initial begin
    #(64'd10 * (64'd5000 * WalkCycles + 100000));
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
